/* hw/rtl/sart_pkg.sv */
// ----------------------------------------------------------------------------
// sart_pkg: shared types for the reuse tracking table
// Opcodes and the request record passed from front end to back end.
// ----------------------------------------------------------------------------
package sart_pkg;

	localparam int unsigned BLOCK_SHIFT = 6;
	localparam int unsigned BLOCK_W     = 64 - BLOCK_SHIFT;
	localparam int unsigned COUNT_W     = 9;

	typedef enum logic [2:0] {
		OP_QUERY        = 3'd0,
		OP_ALLOCATE     = 3'd1,
		OP_MARK         = 3'd2,
		OP_LOOKUP_RESET = 3'd3,
		OP_EVICT        = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_EXEC
	} be_state_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [BLOCK_W-1:0] block;
	} req_t;

endpackage

/* hw/rtl/sart_front.sv */
// ----------------------------------------------------------------------------
// sart_front: request intake
// Splits the address into its block number and queues the request in a
// two-entry FIFO so intake and execution stall independently.
// ----------------------------------------------------------------------------
module sart_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [71:0]         s_tdata,
	output logic                q_valid,
	input  logic                q_ready,
	output sart_pkg::req_t      q_req
);
	import sart_pkg::*;

	req_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_req    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].opcode <= s_tdata[2:0];
			fifo_q[wr_ptr_q].block  <= s_tdata[3+BLOCK_SHIFT +: BLOCK_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* hw/rtl/sart_back.sv */
// ----------------------------------------------------------------------------
// sart_back: table execution
// Folds the block address into its set, reads the set (tags, valid, reuse,
// recency) from memory, resolves the operation, writes back and registers
// the response. Set state is cleared by a pass over all sets after reset.
// ----------------------------------------------------------------------------
module sart_back #(
	parameter int unsigned SETS = 64,
	parameter int unsigned WAYS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  sart_pkg::req_t      q_req,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata
);
	import sart_pkg::*;

	localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned ENT    = SETS * WAYS;
	localparam int unsigned CNT_W  = $clog2(ENT + 1);
	localparam int unsigned RANK_W = WAYS * WAY_W;
	// set = block mod SETS, folded from the top in 12-bit digits:
	// rem = ({rem, digit}) mod SETS, quotient estimated by a reciprocal
	localparam int unsigned DIG_W  = 12;
	localparam int unsigned NDIG   = (BLOCK_W + DIG_W - 1) / DIG_W;
	localparam int unsigned DIG_CW = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam logic [24:0] RECIP  = 25'((64'd1 << 24) / SETS);
	localparam logic [12:0] SETS_C = 13'(SETS);

	be_state_t state_q, state_d;

	logic [WAYS*BLOCK_W-1:0] tag_mem   [SETS];
	logic [WAYS-1:0]         valid_mem [SETS];
	logic [WAYS-1:0]         reuse_mem [SETS];
	// rank per way: 0 most recent, WAYS-1 least recent
	logic [RANK_W-1:0]       rank_mem  [SETS];

	logic [WAYS*BLOCK_W-1:0] tag_rd_q;
	logic [WAYS-1:0]         valid_rd_q, reuse_rd_q;
	logic [RANK_W-1:0]       rank_rd_q;
	logic [CNT_W-1:0]        count_q, count_nx;

	req_t                    req_q;
	logic [SET_W-1:0]        clr_q, set_idx;
	logic [DIG_CW-1:0]       dig_q;
	logic                    phase_q;
	logic [11:0]             rem_q, rem_d;
	logic [23:0]             quo_q;
	logic [NDIG*DIG_W-1:0]   blk_pad;
	logic [23:0]             mod_x, mod_r;
	logic [48:0]             mod_prod;
	logic [36:0]             mod_qs;

	logic                    out_valid_q;
	logic                    out_hit_q, out_reuse_q;
	logic [COUNT_W-1:0]      out_count_q;

	logic [WAYS-1:0]         match;
	logic                    hit, reuse_out;
	logic [WAY_W-1:0]        hit_way, free_way, lru_way, tgt_way;
	logic                    any_free;
	logic                    do_upd, to_front, tgt_valid;
	logic [WAY_W-1:0]        tgt_rank;
	logic                    clearing, exec_go, meta_we;
	logic [SET_W-1:0]        meta_addr;
	logic [WAYS-1:0]         valid_nx, reuse_nx, valid_wd, reuse_wd;
	logic [RANK_W-1:0]       rank_nx, rank_init, rank_wd;

	// set index fold
	assign blk_pad  = (NDIG*DIG_W)'(req_q.block);
	assign mod_x    = {rem_q, blk_pad[dig_q*DIG_W +: DIG_W]};
	assign mod_prod = mod_x * RECIP;
	assign mod_qs   = quo_q * SETS_C;
	assign mod_r    = mod_x - mod_qs[23:0];
	// estimate is low by at most one
	assign rem_d    = (mod_r >= 24'(SETS_C)) ? 12'(mod_r - 24'(SETS_C)) : mod_r[11:0];
	assign set_idx  = rem_q[SET_W-1:0];

	always_comb begin
		unique case (state_q)
			ST_CLEAR: state_d = (clr_q == SET_W'(SETS - 1)) ? ST_IDLE : ST_CLEAR;
			ST_IDLE:  state_d = q_valid ? ST_MOD : ST_IDLE;
			ST_MOD:   state_d = (phase_q && dig_q == '0) ? ST_READ : ST_MOD;
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC:  state_d = exec_go ? ST_IDLE : ST_EXEC;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready  = (state_q == ST_IDLE);
		clearing = (state_q == ST_CLEAR);
		exec_go  = (state_q == ST_EXEC) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			dig_q   <= '0;
			phase_q <= 1'b0;
			rem_q   <= '0;
			quo_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			if (q_valid && q_ready) begin
				dig_q   <= DIG_CW'(NDIG - 1);
				phase_q <= 1'b0;
				rem_q   <= '0;
			end else if (state_q == ST_MOD) begin
				phase_q <= ~phase_q;
				if (!phase_q) begin
					quo_q <= mod_prod[47:24];
				end else begin
					rem_q <= rem_d;
					dig_q <= dig_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) req_q <= q_req;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			tag_rd_q   <= tag_mem[set_idx];
			valid_rd_q <= valid_mem[set_idx];
			reuse_rd_q <= reuse_mem[set_idx];
			rank_rd_q  <= rank_mem[set_idx];
		end
	end

	always_comb begin
		hit_way   = '0;
		free_way  = '0;
		lru_way   = '0;
		any_free  = 1'b0;
		tgt_rank  = '0;
		tgt_valid = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			match[w] = valid_rd_q[w] &&
				(tag_rd_q[w*BLOCK_W +: BLOCK_W] == req_q.block);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) hit_way = WAY_W'(w);
			if (!valid_rd_q[w]) begin
				free_way = WAY_W'(w);
				any_free = 1'b1;
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (rank_rd_q[w*WAY_W +: WAY_W] == WAY_W'(WAYS - 1)) lru_way = WAY_W'(w);
		end
		hit = |match;
		if (hit) tgt_way = hit_way;
		else if (any_free) tgt_way = free_way;
		else tgt_way = lru_way;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == tgt_way) begin
				tgt_rank  = rank_rd_q[w*WAY_W +: WAY_W];
				tgt_valid = valid_rd_q[w];
			end
		end
		do_upd   = (req_q.opcode == OP_ALLOCATE) ||
			(hit && (req_q.opcode == OP_MARK || req_q.opcode == OP_LOOKUP_RESET ||
			req_q.opcode == OP_EVICT));
		to_front = (req_q.opcode != OP_EVICT);
		reuse_out = hit && (req_q.opcode == OP_LOOKUP_RESET) && reuse_rd_q[hit_way];

		valid_nx = valid_rd_q;
		reuse_nx = reuse_rd_q;
		rank_nx  = rank_rd_q;
		count_nx = count_q;
		if (do_upd) begin
			for (int w = 0; w < WAYS; w++) begin
				if (WAY_W'(w) == tgt_way)
					rank_nx[w*WAY_W +: WAY_W] = to_front ? '0 : WAY_W'(WAYS - 1);
				else if (to_front && rank_rd_q[w*WAY_W +: WAY_W] < tgt_rank)
					rank_nx[w*WAY_W +: WAY_W] = rank_rd_q[w*WAY_W +: WAY_W] + 1'b1;
				else if (!to_front && rank_rd_q[w*WAY_W +: WAY_W] > tgt_rank)
					rank_nx[w*WAY_W +: WAY_W] = rank_rd_q[w*WAY_W +: WAY_W] - 1'b1;
			end
			unique case (req_q.opcode)
				OP_ALLOCATE: begin
					valid_nx[tgt_way] = 1'b1;
					reuse_nx[tgt_way] = 1'b0;
					if (!tgt_valid) count_nx = count_q + 1'b1;
				end
				OP_MARK: reuse_nx[tgt_way] = 1'b1;
				OP_LOOKUP_RESET: reuse_nx[tgt_way] = 1'b0;
				OP_EVICT: begin
					valid_nx[tgt_way] = 1'b0;
					reuse_nx[tgt_way] = 1'b0;
					count_nx          = count_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// reset recency: way w at rank w
	always_comb begin
		for (int w = 0; w < WAYS; w++) rank_init[w*WAY_W +: WAY_W] = WAY_W'(w);
	end

	assign meta_we   = clearing || (exec_go && do_upd);
	assign meta_addr = clearing ? clr_q : set_idx;
	assign valid_wd  = clearing ? '0 : valid_nx;
	assign reuse_wd  = clearing ? '0 : reuse_nx;
	assign rank_wd   = clearing ? rank_init : rank_nx;

	always_ff @(posedge clk) begin
		if (meta_we) begin
			valid_mem[meta_addr] <= valid_wd;
			reuse_mem[meta_addr] <= reuse_wd;
			rank_mem[meta_addr]  <= rank_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && req_q.opcode == OP_ALLOCATE)
			tag_mem[set_idx][tgt_way*BLOCK_W +: BLOCK_W] <= req_q.block;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_reuse_q <= 1'b0;
			out_count_q <= '0;
		end else begin
			if (exec_go) begin
				out_valid_q <= 1'b1;
				out_hit_q   <= hit;
				out_reuse_q <= reuse_out;
				out_count_q <= COUNT_W'(count_nx);
				count_q     <= count_nx;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_count_q, out_reuse_q, out_hit_q};

endmodule

/* hw/rtl/set_assoc_reuse_tracking_table.sv */
// ----------------------------------------------------------------------------
// set_assoc_reuse_tracking_table: reuse tracking table with LRU replacement
// Tracks 64-byte blocks in a SETS x WAYS table with valid and reuse bits.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: tdata = {address[63:0], opcode[2:0]} (opcode low).
//   m_* carries one response per request: tdata = hit, reuse, valid_count[8:0]
//   from bit 0 up, zero padded to 16 bits.
//   A two-entry request queue decouples intake from the execution engine.
//   Each request passes through the engine in order: dequeue, fold the
//   block address into its set (five 12-bit digits, each an estimate phase
//   then a remainder phase), read the set from memory, resolve and write
//   back. The engine takes the next request from the queue only after it
//   has finished the current one.
//   The engine holds its result when m_tready is low and does not resolve a
//   request until the output register frees, so intake stops once the
//   queue fills. After reset the engine clears valid/reuse bits and sets
//   ascending-way recency in each of the SETS sets (64 by default);
//   up to two requests queue meanwhile. Tags need no clear.
// ----------------------------------------------------------------------------
module set_assoc_reuse_tracking_table #(
	parameter int unsigned SETS = 64,
	parameter int unsigned WAYS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // opcode[2:0], address[66:3], pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // hit[0], reuse[1], valid_count[10:2], pad
);
	import sart_pkg::*;

	logic q_valid, q_ready;
	req_t q_req;

	sart_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.q_valid, .q_ready, .q_req
	);

	sart_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_req,
		.m_tvalid, .m_tready, .m_tdata
	);

endmodule
